/* design/acirtx_pkg.sv */
package acirtx_pkg;

   localparam int unsigned PULSE_COUNT = 307;
   localparam int unsigned FRAME_BYTES = 19;
   localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;

   localparam logic [8:0] POS_HEADER_MARK  = 9'd0;
   localparam logic [8:0] POS_HEADER_SPACE = 9'd1;
   localparam logic [8:0] POS_FOOTER_MARK  = 9'(PULSE_COUNT - 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam logic [2:0] CSR_HEADER_MARK  = 3'd0;
   localparam logic [2:0] CSR_HEADER_SPACE = 3'd1;
   localparam logic [2:0] CSR_BIT_MARK     = 3'd2;
   localparam logic [2:0] CSR_ONE_SPACE    = 3'd3;
   localparam logic [2:0] CSR_ZERO_SPACE   = 3'd4;
   localparam logic [2:0] CSR_FOOTER_MARK  = 3'd5;

   localparam logic [15:0] RST_HEADER_MARK  = 16'd3588;
   localparam logic [15:0] RST_HEADER_SPACE = 16'd1790;
   localparam logic [15:0] RST_BIT_MARK     = 16'd420;
   localparam logic [15:0] RST_ONE_SPACE    = 16'd1330;
   localparam logic [15:0] RST_ZERO_SPACE   = 16'd470;
   localparam logic [15:0] RST_FOOTER_MARK  = 16'd490;

   localparam logic [7:0] TEMP_DEFAULT_CODE = 8'h1C;
   localparam logic [3:0] POWER_ON_NIBBLE   = 4'b1001;
   localparam logic [3:0] POWER_OFF_NIBBLE  = 4'b0001;

   function automatic logic [7:0] flip8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   // Sum of the bit-reversed fixed bytes 0..4, 7, 9..17 of the frame
   localparam logic [7:0] FIXED_REV_SUM = 8'hF5;

   function automatic logic [7:0] temp_code(input logic [5:0] t);
      logic [7:0] c;
      case (t)
         6'd16: c = 8'h04;
         6'd17: c = 8'h44;
         6'd18: c = 8'h24;
         6'd19: c = 8'h64;
         6'd20: c = 8'h14;
         6'd21: c = 8'h54;
         6'd22: c = 8'h34;
         6'd23: c = 8'h74;
         6'd24: c = 8'h0C;
         6'd25: c = 8'h4C;
         6'd26: c = 8'h2C;
         6'd27: c = 8'h6C;
         6'd28: c = 8'h1C;
         6'd29: c = 8'h5C;
         6'd30: c = 8'h3C;
         default: c = TEMP_DEFAULT_CODE;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] mode_code(input logic [2:0] m);
      logic [3:0] c;
      case (m)
         3'd1: c = 4'hC;
         3'd2: c = 4'h2;
         3'd3: c = 4'h4;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] fan_code(input logic [2:0] f);
      logic [3:0] c;
      case (f)
         3'd1: c = 4'hC;
         3'd2: c = 4'hA;
         3'd3: c = 4'hE;
         default: c = 4'h5;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] swing_code(input logic [2:0] s);
      logic [3:0] c;
      case (s)
         3'd1: c = 4'hA;
         3'd2: c = 4'h2;
         3'd3: c = 4'hC;
         3'd4: c = 4'h4;
         3'd5: c = 4'h8;
         default: c = 4'hF;
      endcase
      return c;
   endfunction

endpackage

/* design/ac_ir_frame_transmitter.sv */
// Channel | Direction | Ports                                          | Handshake
// req     | in        | op, temp_c, ac_mode, power_flag, fan/swing     | req_valid / req_ready
// rsp     | out       | pulse_duration, is_mark, pulse_number, ...     | rsp_valid / rsp_ready
// csr     | in        | csr_index, csr_wdata                           | csr_wr_en, no wait
//
// One word per cycle: a start word builds the frame in its accept cycle, a next
// word puts one pulse into the output register in its accept cycle if a frame is in progress.
// The output register is the only stage; req_ready is low only while it holds
// a word that rsp_ready does not take. Synchronous reset clears the output
// valid, the sending flag and the pulse counter and restores the durations.
module ac_ir_frame_transmitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [5:0]  req_temp_c,
   input  logic [2:0]  req_ac_mode,
   input  logic        req_power_flag,
   input  logic [2:0]  req_fan_speed,
   input  logic [2:0]  req_swing_pos,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pulse_duration,
   output logic        rsp_is_mark,
   output logic [8:0]  rsp_pulse_number,
   output logic        rsp_last_pulse,
   output logic [7:0]  rsp_frame_checksum,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] header_mark_ff, header_space_ff, bit_mark_ff;
   logic [15:0] one_space_ff, zero_space_ff, footer_mark_ff;

   // variable frame bytes 5, 6, 8 and the checksum byte 18
   logic [7:0] byte5_ff, byte5_in;
   logic [7:0] byte6_ff, byte6_in;
   logic [7:0] byte8_ff, byte8_in;
   logic [7:0] csum_ff, csum_in;

   logic       sending_ff, sending_in;
   logic [8:0] pos_ff, pos_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] dur_ff, dur_in;
   logic        mark_ff, mark_in;
   logic [8:0]  num_ff;
   logic        last_ff, last_in;
   logic [7:0]  rsp_csum_ff;

   logic       accept, start, emit;
   logic [8:0] pos_m2;
   logic [7:0] bit_idx;
   logic [7:0] vec_idx;
   logic [acirtx_pkg::FRAME_BITS-1:0] frame_vec;
   logic       data_bit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_op == acirtx_pkg::OP_START);
   assign emit      = accept && (req_op == acirtx_pkg::OP_NEXT) && sending_ff;

   always_comb begin
      byte5_in = {(req_power_flag ? acirtx_pkg::POWER_ON_NIBBLE
                                  : acirtx_pkg::POWER_OFF_NIBBLE),
                  acirtx_pkg::mode_code(req_ac_mode)};
      byte6_in = acirtx_pkg::temp_code(req_temp_c);
      byte8_in = {acirtx_pkg::swing_code(req_swing_pos),
                  acirtx_pkg::fan_code(req_fan_speed)};
      csum_in  = acirtx_pkg::flip8(acirtx_pkg::FIXED_REV_SUM
                                   + acirtx_pkg::flip8(byte5_in)
                                   + acirtx_pkg::flip8(byte6_in)
                                   + acirtx_pkg::flip8(byte8_in));
   end

   assign frame_vec = {8'h40, 8'h04, 8'h07, 8'h20, 8'h00, byte5_ff, byte6_ff,
                       8'h01, byte8_ff, 8'h00, 8'h00, 8'h70, 8'h07, 8'h00,
                       8'h00, 8'h81, 8'h00, 8'h00, csum_ff};

   // byte 0 sits at the top of frame_vec, so bit b is frame_vec[151 - b]
   assign pos_m2   = pos_ff - 9'd2;
   assign bit_idx  = pos_m2[8:1];
   assign vec_idx  = 8'(acirtx_pkg::FRAME_BITS - 1) - bit_idx;
   assign data_bit = frame_vec[vec_idx];

   always_comb begin
      last_in = 1'b0;
      if (pos_ff == acirtx_pkg::POS_HEADER_MARK) begin
         dur_in  = header_mark_ff;
         mark_in = 1'b1;
      end else if (pos_ff == acirtx_pkg::POS_HEADER_SPACE) begin
         dur_in  = header_space_ff;
         mark_in = 1'b0;
      end else if (pos_ff == acirtx_pkg::POS_FOOTER_MARK) begin
         dur_in  = footer_mark_ff;
         mark_in = 1'b1;
         last_in = 1'b1;
      end else if (!pos_m2[0]) begin
         dur_in  = bit_mark_ff;
         mark_in = 1'b1;
      end else begin
         dur_in  = data_bit ? one_space_ff : zero_space_ff;
         mark_in = 1'b0;
      end
   end

   always_comb begin
      sending_in = sending_ff;
      pos_in     = pos_ff;
      if (start) begin
         sending_in = 1'b1;
         pos_in     = '0;
      end else if (emit) begin
         if (last_in) begin
            sending_in = 1'b0;
            pos_in     = '0;
         end else begin
            pos_in = pos_ff + 9'd1;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff      <= 1'b0;
         pos_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         header_mark_ff  <= acirtx_pkg::RST_HEADER_MARK;
         header_space_ff <= acirtx_pkg::RST_HEADER_SPACE;
         bit_mark_ff     <= acirtx_pkg::RST_BIT_MARK;
         one_space_ff    <= acirtx_pkg::RST_ONE_SPACE;
         zero_space_ff   <= acirtx_pkg::RST_ZERO_SPACE;
         footer_mark_ff  <= acirtx_pkg::RST_FOOTER_MARK;
      end else begin
         sending_ff   <= sending_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               acirtx_pkg::CSR_HEADER_MARK:  header_mark_ff  <= csr_wdata;
               acirtx_pkg::CSR_HEADER_SPACE: header_space_ff <= csr_wdata;
               acirtx_pkg::CSR_BIT_MARK:     bit_mark_ff     <= csr_wdata;
               acirtx_pkg::CSR_ONE_SPACE:    one_space_ff    <= csr_wdata;
               acirtx_pkg::CSR_ZERO_SPACE:   zero_space_ff   <= csr_wdata;
               acirtx_pkg::CSR_FOOTER_MARK:  footer_mark_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (start) begin
         byte5_ff <= byte5_in;
         byte6_ff <= byte6_in;
         byte8_ff <= byte8_in;
         csum_ff  <= csum_in;
      end
      if (emit) begin
         dur_ff      <= dur_in;
         mark_ff     <= mark_in;
         num_ff      <= pos_ff;
         last_ff     <= last_in;
         rsp_csum_ff <= csum_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_duration = dur_ff;
   assign rsp_is_mark        = mark_ff;
   assign rsp_pulse_number   = num_ff;
   assign rsp_last_pulse     = last_ff;
   assign rsp_frame_checksum = rsp_csum_ff;

endmodule
